// File: rtl/firmware_image_header_check_assert.svh
// Assertion macros used by the top level of the firmware image header check RTL.
`ifndef FIRMWARE_IMAGE_HEADER_CHECK_ASSERT_SVH
`define FIRMWARE_IMAGE_HEADER_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked only out of reset.
`define FWH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwh assertion failed");
// Next-cycle implication, checked only out of reset.
`define FWH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwh assertion failed");
`else
`define FWH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define FWH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/fwh_pkg.sv
// Package with types, constants and the name table of the image header check.
`default_nettype none
package fwh_pkg;

    // Header layout.
    localparam int HEADER_LEN  = 288;
    localparam int VERSION_LEN = 32;
    localparam int NAME_LEN    = 23;
    localparam int VER_START   = 48;
    localparam int NAME_START  = 80;
    localparam int OFF_W       = 9;
    localparam int PART_W      = 10;
    localparam int PART_MAX    = 999;

    // Fixed byte values.
    localparam logic [7:0] IMAGE_MAGIC = 8'hE9;
    localparam logic [7:0] DESC_MAGIC0 = 8'h32;
    localparam logic [7:0] DESC_MAGIC1 = 8'h54;
    localparam logic [7:0] DESC_MAGIC2 = 8'hCD;
    localparam logic [7:0] DESC_MAGIC3 = 8'hAB;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAJOR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MINOR    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PATCH    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGMENTS = 8'd3;

    // Version parser phase.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_FAILED = 2'd2,
        PH_DONE   = 2'd3
    } t_ver_phase;

    // Status handed from the version parser to the top level.
    typedef struct packed {
        logic              done;
        logic              failed;
        logic [PART_W-1:0] major;
        logic [PART_W-1:0] minor;
        logic [PART_W-1:0] patch;
    } t_ver_status;

    // Expected image name, terminator included.
    function automatic logic [7:0] name_rom(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h67;
            5'd1:    ch = 8'h61;
            5'd2:    ch = 8'h6D;
            5'd3:    ch = 8'h65;
            5'd4:    ch = 8'h78;
            5'd5:    ch = 8'h72;
            5'd6:    ch = 8'h5F;
            5'd7:    ch = 8'h75;
            5'd8:    ch = 8'h73;
            5'd9:    ch = 8'h62;
            5'd10:   ch = 8'h5F;
            5'd11:   ch = 8'h64;
            5'd12:   ch = 8'h69;
            5'd13:   ch = 8'h61;
            5'd14:   ch = 8'h67;
            5'd15:   ch = 8'h6E;
            5'd16:   ch = 8'h6F;
            5'd17:   ch = 8'h73;
            5'd18:   ch = 8'h74;
            5'd19:   ch = 8'h69;
            5'd20:   ch = 8'h63;
            5'd21:   ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fwh_ver_parse.sv
// Parser for the major.minor.patch version string of the image header.
`default_nettype none
module fwh_ver_parse (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_clr,
    input  wire logic [7:0]           i_byte,
    output fwh_pkg::t_ver_status      o_status
);
    import fwh_pkg::*;

    t_ver_phase        r_phase, n_phase;
    logic [1:0]        r_field, n_field;
    logic [PART_W-1:0] r_parts [3];
    logic [PART_W-1:0] n_parts [3];
    logic              r_done, n_done;

    logic              is_digit;
    logic [PART_W-1:0] cur_part;
    logic [13:0]       acc;

    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);

    // Part currently being accumulated, times ten plus the new digit.
    always_comb begin
        case (r_field)
            2'd0:    cur_part = r_parts[0];
            2'd1:    cur_part = r_parts[1];
            2'd2:    cur_part = r_parts[2];
            default: cur_part = '0;
        endcase
        acc = {1'b0, cur_part, 3'b000} + {3'b000, cur_part, 1'b0}
            + {10'd0, i_byte[3:0]};
    end

    // Next state of the parser.
    always_comb begin
        n_phase = r_phase;
        n_field = r_field;
        n_parts = r_parts;
        n_done  = r_done;
        if (i_clr) begin
            n_phase = PH_FIRST;
            n_field = 2'd0;
            n_parts = '{default: '0};
            n_done  = 1'b0;
        end else if (i_en) begin
            unique case (r_phase)
                PH_FIRST, PH_DIGITS: begin
                    if (is_digit) begin
                        if (acc > 14'(PART_MAX)) begin
                            n_phase = PH_FAILED;
                        end else begin
                            n_phase = PH_DIGITS;
                            case (r_field)
                                2'd0:    n_parts[0] = acc[PART_W-1:0];
                                2'd1:    n_parts[1] = acc[PART_W-1:0];
                                default: n_parts[2] = acc[PART_W-1:0];
                            endcase
                        end
                    end else if (r_phase == PH_FIRST) begin
                        n_phase = PH_FAILED;
                    end else if (r_field != 2'd2) begin
                        // A dot separates the parts.
                        if (i_byte == CHAR_DOT) begin
                            n_field = r_field + 2'd1;
                            n_phase = PH_FIRST;
                        end else begin
                            n_phase = PH_FAILED;
                        end
                    end else if (i_byte == 8'h00) begin
                        n_phase = PH_DONE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = PH_FAILED;
                    end
                end
                PH_FAILED, PH_DONE: begin
                    n_phase = r_phase;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_field <= 2'd0;
            r_parts <= '{default: '0};
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_parts <= n_parts;
            r_done  <= n_done;
        end
    end

    assign o_status.done   = r_done;
    assign o_status.failed = (r_phase == PH_FAILED);
    assign o_status.major  = r_parts[0];
    assign o_status.minor  = r_parts[1];
    assign o_status.patch  = r_parts[2];

endmodule
`default_nettype wire

// File: rtl/firmware_image_header_check.sv
// Top level of the firmware image header check.
// Takes one image byte per cycle while the output register is empty or being taken.
// The verdict appears in the output register in the cycle after the last beat
// and holds until taken; the input keeps flowing while the sink is ready.
// Reset clears the offset counter, the check state and the output valid, and
// loads the version minimum 0.4.6 and a segment limit of 16.
`default_nettype none
`include "firmware_image_header_check_assert.svh"
module firmware_image_header_check (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Image byte stream.
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [7:0]                      i_s_tdata,  // [7:0] data_byte
    input  wire logic                            i_s_tlast,
    // Verdict stream.
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [7:0]                           o_m_tdata,  // [0] accepted, [7:1] zero
    // Configuration writes.
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fwh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fwh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fwh_pkg::*;

    logic [PART_W-1:0] r_min_major, r_min_minor, r_min_patch;
    logic [7:0]        r_max_segments;
    logic [OFF_W-1:0]  r_offset;
    logic              r_header_bad;
    logic              r_out_valid;
    logic              r_accepted;

    logic              s_beat;
    logic              check_bad;
    logic              ver_en;
    logic              n_header_bad;
    logic              version_ok;
    logic              verdict;
    logic [OFF_W-1:0]  name_off;
    t_ver_status       ver_status;

    assign s_beat      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_major    <= 10'd0;
            r_min_minor    <= 10'd4;
            r_min_patch    <= 10'd6;
            r_max_segments <= 8'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_MAJOR:    r_min_major    <= i_cfg_data;
                CFG_MIN_MINOR:    r_min_minor    <= i_cfg_data;
                CFG_MIN_PATCH:    r_min_patch    <= i_cfg_data;
                CFG_MAX_SEGMENTS: r_max_segments <= i_cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Fixed-layout checks on the byte at the current offset.
    assign name_off = r_offset - OFF_W'(NAME_START);
    always_comb begin
        check_bad = 1'b0;
        if (r_offset == OFF_W'(0)) begin
            check_bad = (i_s_tdata != IMAGE_MAGIC);
        end else if (r_offset == OFF_W'(1)) begin
            check_bad = (i_s_tdata == 8'h00) || (i_s_tdata > r_max_segments);
        end else if (r_offset == OFF_W'(12) || r_offset == OFF_W'(13)) begin
            check_bad = (i_s_tdata != 8'h00);
        end else if (r_offset == OFF_W'(23)) begin
            check_bad = (i_s_tdata != 8'h01);
        end else if (r_offset == OFF_W'(32)) begin
            check_bad = (i_s_tdata != DESC_MAGIC0);
        end else if (r_offset == OFF_W'(33)) begin
            check_bad = (i_s_tdata != DESC_MAGIC1);
        end else if (r_offset == OFF_W'(34)) begin
            check_bad = (i_s_tdata != DESC_MAGIC2);
        end else if (r_offset == OFF_W'(35)) begin
            check_bad = (i_s_tdata != DESC_MAGIC3);
        end else if (r_offset >= OFF_W'(NAME_START) &&
                     r_offset < OFF_W'(NAME_START + NAME_LEN)) begin
            check_bad = (i_s_tdata != name_rom(name_off[4:0]));
        end
    end

    assign ver_en = s_beat && (r_offset >= OFF_W'(VER_START)) &&
                    (r_offset < OFF_W'(VER_START + VERSION_LEN));

    fwh_ver_parse u_ver (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (ver_en),
        .i_clr    (s_beat && i_s_tlast),
        .i_byte   (i_s_tdata),
        .o_status (ver_status)
    );

    // Lexicographic compare of the parsed version against the minimum.
    always_comb begin
        if (ver_status.major != r_min_major) begin
            version_ok = (ver_status.major > r_min_major);
        end else if (ver_status.minor != r_min_minor) begin
            version_ok = (ver_status.minor > r_min_minor);
        end else begin
            version_ok = (ver_status.patch >= r_min_patch);
        end
    end

    // The last header byte carries no check, so the parser state is final
    // whenever the offset shows a complete header.
    assign n_header_bad = r_header_bad ||
                          ((r_offset < OFF_W'(HEADER_LEN)) && check_bad);
    assign verdict = !n_header_bad && !ver_status.failed && ver_status.done &&
                     (r_offset >= OFF_W'(HEADER_LEN - 1)) && version_ok;

    // Offset counter and sticky header failure.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_header_bad <= 1'b0;
        end else if (s_beat) begin
            if (i_s_tlast) begin
                r_offset     <= '0;
                r_header_bad <= 1'b0;
            end else if (r_offset < OFF_W'(HEADER_LEN)) begin
                r_offset     <= r_offset + OFF_W'(1);
                r_header_bad <= n_header_bad;
            end
        end
    end

    // Output register for the verdict beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_beat && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat && i_s_tlast) begin
            r_accepted <= verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_accepted};

    `FWH_ASSERT_NEXT(a_last_gives_verdict, i_clk, i_rst_n, s_beat && i_s_tlast, o_m_tvalid)
    `FWH_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, s_beat && i_s_tlast, (r_offset == '0) && !r_header_bad && !ver_status.done)
    `FWH_ASSERT_IMPLIES(a_offset_bound, i_clk, i_rst_n, 1'b1, r_offset <= OFF_W'(HEADER_LEN))
    `FWH_ASSERT_NEXT(a_offset_steps, i_clk, i_rst_n, s_beat && !i_s_tlast && (r_offset < OFF_W'(HEADER_LEN)), r_offset == $past(r_offset) + OFF_W'(1))

endmodule
`default_nettype wire

// File: bench/firmware_image_header_check_test.sv
// Self-checking bench for the firmware image header check: directed and random images against a model.
module firmware_image_header_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fwh_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IMG_MAX      = 400;
    localparam int PRINT_MAX    = 40;
    localparam int ITEM_TARGET  = 1800;

    // Ways to spoil an otherwise well-formed image.
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_SEG_ZERO,
        FLAW_SEG_HIGH,
        FLAW_ZERO_BYTES,
        FLAW_ONE_BYTE,
        FLAW_DESC,
        FLAW_NAME,
        FLAW_VER_CHAR,
        FLAW_VER_BIG,
        FLAW_VER_EMPTY,
        FLAW_VER_OPEN
    } t_flaw;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_image_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;   // [7:0] data_byte
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;        // [0] accepted, [7:1] zero
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    firmware_image_header_check u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Expected image name at offset 80, terminator included.
    logic [7:0] expected_name [0:NAME_LEN-1] = '{
        8'h67, 8'h61, 8'h6d, 8'h65, 8'h78, 8'h72, 8'h5f, 8'h75,
        8'h73, 8'h62, 8'h5f, 8'h64, 8'h69, 8'h61, 8'h67, 8'h6e,
        8'h6f, 8'h73, 8'h74, 8'h69, 8'h63, 8'h73, 8'h00
    };

    // Bench copy of the configuration registers.
    logic [9:0] cfg_min_major = 10'd0;
    logic [9:0] cfg_min_minor = 10'd4;
    logic [9:0] cfg_min_patch = 10'd6;
    logic [7:0] cfg_max_segments = 8'd16;

    // Bench copy of the per-image check state.
    int         img_offset = 0;
    bit         hdr_bad = 1'b0;
    int         ver_field = 0;
    t_ver_phase ver_phase = PH_FIRST;
    int         ver_parts [0:2] = '{0, 0, 0};
    bit         ver_done = 1'b0;

    t_image_beat byte_q [$];
    bit          verdict_q [$];
    t_image_beat next_beat;

    logic [7:0] img [0:IMG_MAX-1];
    int         ver_text_len;

    int  src_gap = 0;
    int  sink_wait = 0;
    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;
    bit  hold_go = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;
    int  err_count = 0;
    int  verdicts_seen = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_count < PRINT_MAX)
            $display("mismatch at verdict %0d: %s, got %h want %h",
                     verdicts_seen, what, got, want);
        err_count++;
    endtask

    // One character of the version text; any deviation marks the header bad.
    task automatic parse_version_char(input logic [7:0] b);
        bit is_digit;
        int f;
        int v;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        f = ver_field;
        if (ver_phase == PH_FAILED || ver_phase == PH_DONE || f > 2)
            return;
        if (is_digit) begin
            v = ver_parts[f] * 10 + int'(b - CHAR_ZERO);
            if (v > PART_MAX) begin
                ver_phase = PH_FAILED;
                hdr_bad = 1'b1;
            end else begin
                ver_parts[f] = v;
                ver_phase = PH_DIGITS;
            end
        end else if (ver_phase == PH_FIRST) begin
            ver_phase = PH_FAILED;
            hdr_bad = 1'b1;
        end else if (f < 2) begin
            if (b != CHAR_DOT) begin
                ver_phase = PH_FAILED;
                hdr_bad = 1'b1;
            end else begin
                ver_field = f + 1;
                ver_phase = PH_FIRST;
            end
        end else if (b != 8'h00) begin
            ver_phase = PH_FAILED;
            hdr_bad = 1'b1;
        end else begin
            ver_phase = PH_DONE;
            ver_done = 1'b1;
        end
    endtask

    function automatic bit version_meets_min();
        if (ver_parts[0] != int'(cfg_min_major))
            return ver_parts[0] > int'(cfg_min_major);
        if (ver_parts[1] != int'(cfg_min_minor))
            return ver_parts[1] > int'(cfg_min_minor);
        return ver_parts[2] >= int'(cfg_min_patch);
    endfunction

    // Advance the image check by one accepted beat; queue a verdict on the last one.
    task automatic image_check_byte(input logic [7:0] b, input logic is_last);
        bit bad;
        bad = 1'b0;
        if (img_offset < HEADER_LEN) begin
            if (img_offset == 0)
                bad = b != IMAGE_MAGIC;
            else if (img_offset == 1)
                bad = (b == 8'h00) || (b > cfg_max_segments);
            else if (img_offset == 12 || img_offset == 13)
                bad = b != 8'h00;
            else if (img_offset == 23)
                bad = b != 8'h01;
            else if (img_offset == 32)
                bad = b != DESC_MAGIC0;
            else if (img_offset == 33)
                bad = b != DESC_MAGIC1;
            else if (img_offset == 34)
                bad = b != DESC_MAGIC2;
            else if (img_offset == 35)
                bad = b != DESC_MAGIC3;
            else if (img_offset >= VER_START && img_offset < VER_START + VERSION_LEN)
                parse_version_char(b);
            else if (img_offset >= NAME_START && img_offset < NAME_START + NAME_LEN)
                bad = b != expected_name[img_offset - NAME_START];
            if (bad)
                hdr_bad = 1'b1;
            img_offset++;
        end
        if (is_last) begin
            verdict_q.push_back(!hdr_bad && img_offset >= HEADER_LEN && ver_done &&
                                version_meets_min());
            img_offset = 0;
            hdr_bad = 1'b0;
            ver_field = 0;
            ver_phase = PH_FIRST;
            ver_parts = '{0, 0, 0};
            ver_done = 1'b0;
        end
    endtask

    function automatic int pick_src_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Source side: one beat offered at a time from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            i_s_tlast <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                image_check_byte(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    next_beat = byte_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= next_beat.data;
                    i_s_tlast <= next_beat.is_last;
                    src_gap <= pick_src_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Sink side: check each verdict beat, then decide the next ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none expected", o_m_tdata, 8'h00);
                end else begin
                    if (o_m_tdata[0] !== verdict_q[0])
                        report_mismatch("accepted", o_m_tdata, {7'd0, verdict_q[0]});
                    if (o_m_tdata[7:1] !== 7'd0)
                        report_mismatch("padding bits", o_m_tdata, {7'd0, verdict_q[0]});
                    void'(verdict_q.pop_front());
                end
                verdicts_seen++;
            end
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
            end else if (sink_wait != 0) begin
                sink_wait <= sink_wait - 1;
                i_m_tready <= 1'b0;
            end else if (!sink_calm && $urandom_range(0, 99) < 30) begin
                sink_wait <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(15, 60);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_MIN_MAJOR:    cfg_min_major = 10'(value);
            CFG_MIN_MINOR:    cfg_min_minor = 10'(value);
            CFG_MIN_PATCH:    cfg_min_patch = 10'(value);
            CFG_MAX_SEGMENTS: cfg_max_segments = 8'(value);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input bit src, input bit sink);
        @(posedge i_clk);
        src_calm <= src;
        sink_calm <= sink;
    endtask

    // Wait until every beat is sent and every verdict is back, plus a short tail.
    task automatic wait_idle();
        @(negedge i_clk);
        while (byte_q.size() != 0 || i_s_tvalid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input int major, input int minor, input int patch,
                              input int segs);
        wait_idle();
        write_register(CFG_MIN_MAJOR, major);
        write_register(CFG_MIN_MINOR, minor);
        write_register(CFG_MIN_PATCH, patch);
        write_register(CFG_MAX_SEGMENTS, segs);
    endtask

    // Version text at offset 48; an empty part or a missing terminator on request.
    task automatic write_version(input int major, input int minor, input int patch,
                                 input int empty_idx, input bit open_end);
        int    parts [0:2];
        int    pos;
        int    lead;
        int    lead_max;
        string s;
        parts = '{major, minor, patch};
        pos = VER_START;
        lead_max = ($urandom_range(0, 99) < 15) ? 2 : 0;
        for (int p = 0; p < 3; p++) begin
            if (p != empty_idx) begin
                s = $sformatf("%0d", parts[p]);
                lead = $urandom_range(0, lead_max);
                if (open_end && p == 2)
                    lead = VER_START + VERSION_LEN - pos - s.len();
                repeat (lead) begin
                    img[pos] = CHAR_ZERO;
                    pos++;
                end
                for (int i = 0; i < s.len(); i++) begin
                    img[pos] = s[i];
                    pos++;
                end
            end
            if (p < 2) begin
                img[pos] = CHAR_DOT;
                pos++;
            end
        end
        if (!open_end) begin
            img[pos] = 8'h00;
            pos++;
        end
        ver_text_len = pos - VER_START;
    endtask

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // Well-formed image with random filler, then at most one flaw.
    task automatic build_image(input int major, input int minor, input int patch,
                               input int segs, input t_flaw flaw);
        int         pick;
        logic [7:0] c;
        for (int i = 0; i < IMG_MAX; i++)
            img[i] = 8'($urandom_range(0, 255));
        img[0] = IMAGE_MAGIC;
        img[1] = 8'(segs);
        img[12] = 8'h00;
        img[13] = 8'h00;
        img[23] = 8'h01;
        img[32] = DESC_MAGIC0;
        img[33] = DESC_MAGIC1;
        img[34] = DESC_MAGIC2;
        img[35] = DESC_MAGIC3;
        for (int i = 0; i < NAME_LEN; i++)
            img[NAME_START + i] = expected_name[i];
        pick = $urandom_range(0, 2);
        case (flaw)
            FLAW_VER_BIG: begin
                if (pick == 0) major = $urandom_range(1000, 9999);
                else if (pick == 1) minor = $urandom_range(1000, 9999);
                else patch = $urandom_range(1000, 9999);
                write_version(major, minor, patch, -1, 1'b0);
            end
            FLAW_VER_EMPTY: write_version(major, minor, patch, pick, 1'b0);
            FLAW_VER_OPEN:  write_version(major, minor, patch, -1, 1'b1);
            default:        write_version(major, minor, patch, -1, 1'b0);
        endcase
        case (flaw)
            FLAW_MAGIC:      img[0] = IMAGE_MAGIC ^ nonzero_byte();
            FLAW_SEG_ZERO:   img[1] = 8'h00;
            FLAW_SEG_HIGH:   img[1] = (cfg_max_segments == 8'hff) ? 8'h00 :
                                 8'($urandom_range(int'(cfg_max_segments) + 1, 255));
            FLAW_ZERO_BYTES: img[12 + $urandom_range(0, 1)] = nonzero_byte();
            FLAW_ONE_BYTE:   img[23] = 8'h01 ^ nonzero_byte();
            FLAW_DESC:       img[32 + pick] = img[32 + pick] ^ nonzero_byte();
            FLAW_NAME: begin
                pick = $urandom_range(0, NAME_LEN - 1);
                img[NAME_START + pick] = img[NAME_START + pick] ^ nonzero_byte();
            end
            FLAW_VER_CHAR: begin
                // Neither digit, dot nor terminator, so the text can never parse.
                do
                    c = nonzero_byte();
                while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT);
                img[VER_START + $urandom_range(0, ver_text_len - 1)] = c;
            end
            default: ;
        endcase
    endtask

    task automatic send_image(input int len);
        t_image_beat beat;
        @(negedge i_clk);
        for (int i = 0; i < len; i++) begin
            beat.data = img[i];
            beat.is_last = (i == len - 1);
            byte_q.push_back(beat);
        end
        bytes_sent += len;
    endtask

    // Version parts near the configured minimum so both verdicts are common.
    function automatic int pick_part(input int floor_val);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return floor_val;
        if (r < 5)
            return (floor_val >= PART_MAX) ? PART_MAX : floor_val + 1;
        if (r < 7)
            return (floor_val == 0) ? 0 : floor_val - 1;
        return $urandom_range(0, PART_MAX);
    endfunction

    function automatic int pick_segments();
        if (cfg_max_segments == 8'h00)
            return $urandom_range(1, 255);
        if ($urandom_range(0, 3) == 0)
            return int'(cfg_max_segments);
        return $urandom_range(1, int'(cfg_max_segments));
    endfunction

    task automatic send_random_image();
        int    r;
        int    r2;
        int    len;
        t_flaw flaw;
        r = $urandom_range(0, 99);
        flaw = FLAW_NONE;
        if (r >= 55 && r < 88)
            flaw = t_flaw'($urandom_range(int'(FLAW_MAGIC), int'(FLAW_VER_OPEN)));
        build_image(pick_part(int'(cfg_min_major)), pick_part(int'(cfg_min_minor)),
                    pick_part(int'(cfg_min_patch)), pick_segments(), flaw);
        r2 = $urandom_range(0, 99);
        if (r >= 95) begin
            // Pure noise.
            for (int i = 0; i < IMG_MAX; i++)
                img[i] = 8'($urandom_range(0, 255));
            len = HEADER_LEN + $urandom_range(0, 8);
        end else if (r >= 88) begin
            // Cut short before the header ends.
            len = (r2 < 20) ? 1 : (r2 < 40) ? HEADER_LEN - 1
                                            : $urandom_range(2, HEADER_LEN - 2);
        end else begin
            len = HEADER_LEN + ((r2 < 40) ? 0 : (r2 < 90) ? $urandom_range(1, 8)
                                                          : $urandom_range(20, 100));
        end
        send_image(len);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed images under the reset configuration 0.4.6, limit 16: a version
        // right at the minimum, one just below it, and two images cut short.
        build_image(0, 4, 6, 16, FLAW_NONE);
        send_image(HEADER_LEN);
        build_image(0, 4, 5, 1, FLAW_NONE);
        send_image(HEADER_LEN);
        build_image(1, 0, 0, 2, FLAW_NONE);
        send_image(1);
        build_image(1, 0, 0, 2, FLAW_NONE);
        send_image(HEADER_LEN - 1);

        // Lowest minimum, widest segment range; the sink holds off while short
        // images keep arriving so the block backs up.
        set_config(0, 0, 0, 255);
        set_idling(1'b1, 1'b0);
        hold_go <= 1'b1;
        @(negedge i_clk);
        while (hold_left == 0)
            @(negedge i_clk);
        for (int n = 0; n < 24; n++) begin
            build_image(1, 1, 1, 1, FLAW_NONE);
            send_image($urandom_range(1, 3));
        end

        // Highest minimum, single segment, no idling on either side; the largest
        // parts pass and the bytes past the header are ignored.
        set_config(999, 999, 999, 1);
        set_idling(1'b1, 1'b1);
        build_image(999, 999, 999, 1, FLAW_NONE);
        send_image(HEADER_LEN + 40);

        // A zero segment limit rejects everything.
        wait_idle();
        set_idling(1'b0, 1'b0);
        write_register(CFG_MAX_SEGMENTS, 0);
        send_random_image();

        // Random settings until the byte budget is spent.
        while (bytes_sent < ITEM_TARGET) begin
            set_config(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, PART_MAX),
                       $urandom_range(0, PART_MAX), $urandom_range(0, PART_MAX),
                       $urandom_range(1, 255));
            send_random_image();
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
